/* rtl/bbl_pkg.sv */
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared types and constants for the byte-budget LRU cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package bbl_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_W    = 8;
  localparam int PART_W   = 40;
  localparam int SIZE_W   = 42;
  localparam int USED_W   = 48;
  localparam int STAMP_W  = 64;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 2'd0,
    ST_INSERT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_HIT,
    S_EVICT,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   layer;
    logic [KEY_W-1:0]   expert;
    logic [SIZE_W-1:0]  bytes;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] rd_addr;
    logic             cmp_en;
    logic [IDX_W-1:0] cmp_idx;
    logic             hit_upd;
    logic             evict;
    logic             fill;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic do_evict;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/bbl_req_if.sv */
// ----------------------------------------------------------------------------
// bbl_req_if
// Request channel: valid/ready with the lookup key and part sizes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbl_req_if;
  import bbl_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  layer;
  logic [KEY_W-1:0]  expert;
  logic              has_first;
  logic [PART_W-1:0] first_bytes;
  logic              has_second;
  logic [PART_W-1:0] second_bytes;
  logic              has_third;
  logic [PART_W-1:0] third_bytes;

  modport source (
    output valid, layer, expert, has_first, first_bytes,
           has_second, second_bytes, has_third, third_bytes,
    input  ready
  );

  modport sink (
    input  valid, layer, expert, has_first, first_bytes,
           has_second, second_bytes, has_third, third_bytes,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/bbl_rsp_if.sv */
// ----------------------------------------------------------------------------
// bbl_rsp_if
// Response channel: valid/ready with the lookup outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbl_rsp_if;
  import bbl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                evicted;
  logic [KEY_W-1:0]    evicted_layer;
  logic [KEY_W-1:0]    evicted_expert;
  logic [SLOT_W-1:0]   slot;
  logic [USED_W-1:0]   used_bytes;

  modport source (
    output valid, status, evicted, evicted_layer, evicted_expert, slot, used_bytes,
    input  ready
  );

  modport sink (
    input  valid, status, evicted, evicted_layer, evicted_expert, slot, used_bytes,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/bbl_ram.sv */
// ----------------------------------------------------------------------------
// bbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/bbl_ctrl.sv */
// ----------------------------------------------------------------------------
// bbl_ctrl
// Sequencer: scans the directory, then steps through hit, or evict and fill,
// or fill alone, and loads the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  wire logic         rsp_ready,
  input  wire bbl_pkg::sts_t sts,
  output bbl_pkg::cmd_t     cmd
);
  import bbl_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             scan_last;
  logic             out_free;

  assign scan_last = (cnt == CNT_W'(ENTRIES));
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_valid) state_next = S_SCAN;
      S_SCAN:  if (scan_last) state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.hit) state_next = S_HIT;
        else if (sts.do_evict) state_next = S_EVICT;
        else state_next = S_FILL;
      end
      S_HIT:   state_next = S_DONE;
      S_EVICT: state_next = S_FILL;
      S_FILL:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    req_ready    = (state == S_IDLE);
    cmd.load     = (state == S_IDLE) && req_valid;
    cmd.rd_addr  = (state == S_SCAN && !scan_last) ? cnt[IDX_W-1:0] : '0;
    cmd.cmp_en   = (state == S_SCAN) && (cnt != '0);
    cmd.cmp_idx  = IDX_W'(cnt - CNT_W'(1));
    cmd.hit_upd  = (state == S_HIT);
    cmd.evict    = (state == S_EVICT);
    cmd.fill     = (state == S_FILL);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bbl_dp.sv */
// ----------------------------------------------------------------------------
// bbl_dp
// Datapath: entry RAM, valid bits, scan trackers for hit, victim and free
// slot, use clock, byte accounting and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bbl_pkg::USED_W-1:0]    cfg_wdata,
  input  wire logic [bbl_pkg::KEY_W-1:0]     layer,
  input  wire logic [bbl_pkg::KEY_W-1:0]     expert,
  input  wire logic                          has_first,
  input  wire logic [bbl_pkg::PART_W-1:0]    first_bytes,
  input  wire logic                          has_second,
  input  wire logic [bbl_pkg::PART_W-1:0]    second_bytes,
  input  wire logic                          has_third,
  input  wire logic [bbl_pkg::PART_W-1:0]    third_bytes,
  input  wire bbl_pkg::cmd_t                 cmd,
  output bbl_pkg::sts_t                      sts,
  output logic [bbl_pkg::STATUS_W-1:0]       status,
  output logic                               evicted,
  output logic [bbl_pkg::KEY_W-1:0]          evicted_layer,
  output logic [bbl_pkg::KEY_W-1:0]          evicted_expert,
  output logic [bbl_pkg::SLOT_W-1:0]         slot,
  output logic [bbl_pkg::USED_W-1:0]         used_bytes
);
  import bbl_pkg::*;

  logic [USED_W-1:0]  budget;
  logic [ENTRIES-1:0] valid_q;
  logic [STAMP_W-1:0] use_clock;
  logic [USED_W-1:0]  in_use;

  logic [KEY_W-1:0]   key_layer, key_expert;
  logic [PART_W-1:0]  part_a, part_b, part_c;
  logic [SIZE_W-1:0]  size_q;

  logic               hit_found, vic_found, free_found, ev_done;
  logic [IDX_W-1:0]   hit_idx, vic_idx, free_idx, slot_q;
  logic [SIZE_W-1:0]  hit_bytes;
  entry_t             vic;

  entry_t             rd_entry, wr_entry;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   fill_idx;
  logic [STAMP_W-1:0] clock_inc;
  logic               size_zero;
  logic [USED_W:0]    add_sum;
  logic [USED_W-1:0]  sub_bytes;
  status_t            res_status;

  bbl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (cmd.rd_addr),
    .rdata (rd_entry)
  );

  assign clock_inc = use_clock + STAMP_W'(1);
  assign size_zero = (size_q == '0);
  assign sub_bytes = USED_W'(vic.bytes);
  assign add_sum   = {1'b0, in_use} + (USED_W + 1)'(size_q);

  assign fill_idx = (ev_done && (!free_found || vic_idx < free_idx)) ? vic_idx : free_idx;

  assign sts.hit      = hit_found;
  assign sts.do_evict = vic_found && ((in_use >= budget) || !free_found);

  always_comb begin
    ram_we          = cmd.hit_upd || (cmd.fill && !size_zero);
    ram_waddr       = cmd.hit_upd ? hit_idx : fill_idx;
    wr_entry.layer  = key_layer;
    wr_entry.expert = key_expert;
    wr_entry.bytes  = cmd.hit_upd ? hit_bytes : size_q;
    wr_entry.stamp  = clock_inc;
  end

  always_comb begin
    if (hit_found) res_status = ST_HIT;
    else if (size_zero) res_status = ST_REJECT;
    else res_status = ST_INSERT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget    <= '0;
      valid_q   <= '0;
      use_clock <= '0;
      in_use    <= '0;
    end else begin
      if (cfg_we) begin
        budget <= cfg_wdata;
      end
      if (cmd.hit_upd || cmd.fill) begin
        use_clock <= clock_inc;
      end
      if (cmd.evict) begin
        valid_q[vic_idx] <= 1'b0;
        in_use <= (in_use >= sub_bytes) ? in_use - sub_bytes : '0;
      end
      if (cmd.fill && !size_zero) begin
        valid_q[fill_idx] <= 1'b1;
        in_use <= add_sum[USED_W] ? {USED_W{1'b1}} : add_sum[USED_W-1:0];
      end
    end
  end

  // request capture and directory scan
  always_ff @(posedge clk) begin
    size_q <= SIZE_W'(part_a) + SIZE_W'(part_b) + SIZE_W'(part_c);
    if (cmd.load) begin
      key_layer  <= layer;
      key_expert <= expert;
      part_a     <= has_first  ? first_bytes  : '0;
      part_b     <= has_second ? second_bytes : '0;
      part_c     <= has_third  ? third_bytes  : '0;
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
      ev_done    <= 1'b0;
    end
    if (cmd.cmp_en) begin
      if (valid_q[cmd.cmp_idx]) begin
        if (!hit_found && rd_entry.layer == key_layer && rd_entry.expert == key_expert) begin
          hit_found <= 1'b1;
          hit_idx   <= cmd.cmp_idx;
          hit_bytes <= rd_entry.bytes;
        end
        if (!vic_found || rd_entry.stamp < vic.stamp) begin
          vic_found <= 1'b1;
          vic_idx   <= cmd.cmp_idx;
          vic       <= rd_entry;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmd.cmp_idx;
      end
    end
    if (cmd.evict) begin
      ev_done <= 1'b1;
    end
    if (cmd.fill) begin
      slot_q <= fill_idx;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      evicted        <= ev_done;
      evicted_layer  <= ev_done ? vic.layer : '0;
      evicted_expert <= ev_done ? vic.expert : '0;
      if (hit_found) begin
        slot <= SLOT_W'(hit_idx);
      end else if (size_zero) begin
        slot <= '0;
      end else begin
        slot <= SLOT_W'(slot_q);
      end
      used_bytes <= in_use;
    end
  end

endmodule

`default_nettype wire

/* rtl/byte_budget_lru_cache_unit.sv */
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_unit
// Fully associative (layer, expert) directory with LRU replacement under a
// programmable byte budget.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     contents
//  cfg      in   cfg_we        cfg_wdata: byte budget (48 bits)
//  req      in   valid/ready   key, three part flags and sizes
//  rsp      out  valid/ready   status, eviction, slot, bytes in use
//
//  A request steps through one RAM read per entry during the scan, a
//  decision step, then hit or evict/fill update, then load of the response
//  register.
//  The next request is taken while a response waits; a stalled response
//  holds the block only at its final step.
//  Reset clears the valid bits, use clock, bytes in use and budget at once.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_budget_lru_cache_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [bbl_pkg::USED_W-1:0] cfg_wdata,
  bbl_req_if.sink                         req,
  bbl_rsp_if.source                       rsp
);
  import bbl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .layer          (req.layer),
    .expert         (req.expert),
    .has_first      (req.has_first),
    .first_bytes    (req.first_bytes),
    .has_second     (req.has_second),
    .second_bytes   (req.second_bytes),
    .has_third      (req.has_third),
    .third_bytes    (req.third_bytes),
    .cmd            (cmd),
    .sts            (sts),
    .status         (rsp.status),
    .evicted        (rsp.evicted),
    .evicted_layer  (rsp.evicted_layer),
    .evicted_expert (rsp.evicted_expert),
    .slot           (rsp.slot),
    .used_bytes     (rsp.used_bytes)
  );

endmodule

`default_nettype wire

/* test/tb_byte_budget_lru_cache_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_budget_lru_cache_unit
// Self-checking bench for the byte-budget LRU cache directory. A queue-fed
// driver offers lookups with random gaps. A scoreboard model of the
// directory predicts every response as its request transfers. The monitor
// stalls at random and compares each response field by field. Budget
// changes are made only while the block is drained.
// ----------------------------------------------------------------------------

module tb_byte_budget_lru_cache_unit;
  import bbl_pkg::*;

  typedef struct {
    logic [KEY_W-1:0]  layer;
    logic [KEY_W-1:0]  expert;
    logic              has_first;
    logic [PART_W-1:0] first_bytes;
    logic              has_second;
    logic [PART_W-1:0] second_bytes;
    logic              has_third;
    logic [PART_W-1:0] third_bytes;
  } lookup_req_t;

  typedef struct {
    status_t           status;
    logic              evicted;
    logic [KEY_W-1:0]  ev_layer;
    logic [KEY_W-1:0]  ev_expert;
    logic [SLOT_W-1:0] slot;
    logic [USED_W-1:0] used;
  } lookup_rsp_t;

  typedef enum int {SIZE_SMALL, SIZE_WIDE, SIZE_MIXED} size_mode_t;

  localparam int POOL_N   = 24;
  localparam int N_PHASES = 8;
  localparam logic [USED_W-1:0] BUDGET_MAX = '1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [USED_W-1:0] cfg_wdata;

  bbl_req_if req_ch();
  bbl_rsp_if rsp_ch();

  byte_budget_lru_cache_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // directory model
  logic               dir_valid [ENTRIES];
  logic [KEY_W-1:0]   dir_layer [ENTRIES];
  logic [KEY_W-1:0]   dir_expert[ENTRIES];
  logic [SIZE_W-1:0]  dir_bytes [ENTRIES];
  logic [STAMP_W-1:0] dir_stamp [ENTRIES];
  logic [STAMP_W-1:0] lru_clock;
  logic [USED_W-1:0]  bytes_used;
  logic [USED_W-1:0]  budget_reg;

  lookup_req_t pending_req[$];
  lookup_rsp_t want_rsp[$];

  logic [KEY_W-1:0] pool_layer [POOL_N];
  logic [KEY_W-1:0] pool_expert[POOL_N];
  size_mode_t size_mode;

  int  n_fail     = 0;
  int  n_accepted = 0;
  int  n_hit      = 0;
  int  n_insert   = 0;
  int  n_reject   = 0;
  int  n_evict    = 0;
  int  n_settings = 0;
  int  drv_gap    = 0;
  int  mon_gap    = 0;
  bit  drv_quiet  = 1'b0;
  bit  mon_quiet  = 1'b0;
  bit  hold_rsp   = 1'b0;
  lookup_rsp_t got_rsp;

  task automatic predict_lookup(input lookup_req_t it);
    lookup_rsp_t r;
    int hit_i;
    int victim;
    int free_i;
    bit full;
    logic [SIZE_W-1:0] size;
    logic [USED_W:0]   sum;
    hit_i    = -1;
    victim   = -1;
    free_i   = -1;
    full     = 1'b1;
    r.status    = ST_HIT;
    r.evicted   = 1'b0;
    r.ev_layer  = '0;
    r.ev_expert = '0;
    r.slot      = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (dir_valid[i]) begin
        if (hit_i < 0 && dir_layer[i] == it.layer && dir_expert[i] == it.expert) hit_i = i;
      end else begin
        full = 1'b0;
      end
    end
    if (hit_i >= 0) begin
      lru_clock++;
      dir_stamp[hit_i] = lru_clock;
      r.slot = SLOT_W'(hit_i);
    end else begin
      if (bytes_used >= budget_reg || full) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (dir_valid[i] && (victim < 0 || dir_stamp[i] < dir_stamp[victim])) victim = i;
        end
        if (victim >= 0) begin
          dir_valid[victim] = 1'b0;
          bytes_used = (bytes_used >= dir_bytes[victim]) ? bytes_used - dir_bytes[victim] : '0;
          r.evicted   = 1'b1;
          r.ev_layer  = dir_layer[victim];
          r.ev_expert = dir_expert[victim];
        end
      end
      lru_clock++;
      size = '0;
      if (it.has_first)  size = size + it.first_bytes;
      if (it.has_second) size = size + it.second_bytes;
      if (it.has_third)  size = size + it.third_bytes;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!dir_valid[i] && free_i < 0) free_i = i;
      end
      if (size == 0 || free_i < 0) begin
        r.status = ST_REJECT;
      end else begin
        dir_valid[free_i]  = 1'b1;
        dir_layer[free_i]  = it.layer;
        dir_expert[free_i] = it.expert;
        dir_bytes[free_i]  = size;
        dir_stamp[free_i]  = lru_clock;
        sum = bytes_used + size;
        bytes_used = sum[USED_W] ? BUDGET_MAX : sum[USED_W-1:0];
        r.slot   = SLOT_W'(free_i);
        r.status = ST_INSERT;
      end
    end
    r.used = bytes_used;
    want_rsp = {want_rsp, r};
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      n_fail++;
    end
  endtask

  function automatic logic [PART_W-1:0] draw_part();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) return '0;
    case (size_mode)
      SIZE_SMALL: return PART_W'($urandom_range(1, 4095));
      SIZE_WIDE: begin
        if ($urandom_range(0, 15) == 0) return '1;
        return r[PART_W-1:0];
      end
      default: return $urandom_range(0, 1) ? PART_W'($urandom_range(1, 4095)) : r[PART_W-1:0];
    endcase
  endfunction

  function automatic lookup_req_t rand_lookup();
    lookup_req_t it;
    int k;
    if ($urandom_range(0, 9) == 0) begin
      it.layer  = KEY_W'($urandom);
      it.expert = KEY_W'($urandom);
    end else begin
      k = $urandom_range(0, POOL_N - 1);
      it.layer  = pool_layer[k];
      it.expert = pool_expert[k];
    end
    it.has_first    = ($urandom_range(0, 4) != 0);
    it.has_second   = ($urandom_range(0, 4) != 0);
    it.has_third    = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 19) == 0) {it.has_first, it.has_second, it.has_third} = 3'b000;
    it.first_bytes  = draw_part();
    it.second_bytes = draw_part();
    it.third_bytes  = draw_part();
    return it;
  endfunction

  task automatic queue_lookup(input logic [KEY_W-1:0] layer, input logic [KEY_W-1:0] expert,
                              input logic hf, input logic [PART_W-1:0] fb,
                              input logic hs, input logic [PART_W-1:0] sb,
                              input logic ht, input logic [PART_W-1:0] tb);
    lookup_req_t it;
    it.layer        = layer;
    it.expert       = expert;
    it.has_first    = hf;
    it.first_bytes  = fb;
    it.has_second   = hs;
    it.second_bytes = sb;
    it.has_third    = ht;
    it.third_bytes  = tb;
    pending_req = {pending_req, it};
  endtask

  task automatic drain_and_settle();
    do @(negedge clk); while (pending_req.size() != 0 || want_rsp.size() != 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_budget(input logic [USED_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    budget_reg  = v;
    n_settings++;
    @(negedge clk);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.layer = '0;
    req_ch.expert = '0;
    req_ch.has_first = 1'b0;
    req_ch.first_bytes = '0;
    req_ch.has_second = 1'b0;
    req_ch.second_bytes = '0;
    req_ch.has_third = 1'b0;
    req_ch.third_bytes = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i]  = 1'b0;
      dir_layer[i]  = '0;
      dir_expert[i] = '0;
      dir_bytes[i]  = '0;
      dir_stamp[i]  = '0;
    end
    lru_clock  = '0;
    bytes_used = '0;
    budget_reg = '0;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_lookup(pending_req.pop_front());
        n_accepted++;
        if ($urandom_range(0, 49) == 0) drv_quiet = !drv_quiet;
        drv_gap = drv_quiet ? 0 : $urandom_range(0, 17);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_req.size() != 0) begin
          req_ch.layer        <= pending_req[0].layer;
          req_ch.expert       <= pending_req[0].expert;
          req_ch.has_first    <= pending_req[0].has_first;
          req_ch.first_bytes  <= pending_req[0].first_bytes;
          req_ch.has_second   <= pending_req[0].has_second;
          req_ch.second_bytes <= pending_req[0].second_bytes;
          req_ch.has_third    <= pending_req[0].has_third;
          req_ch.third_bytes  <= pending_req[0].third_bytes;
          req_ch.valid        <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      mon_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (want_rsp.size() == 0) begin
          $error("response transfer with no request outstanding");
          n_fail++;
        end else begin
          got_rsp = want_rsp.pop_front();
          check_field("status", got_rsp.status, rsp_ch.status);
          check_field("evicted", got_rsp.evicted, rsp_ch.evicted);
          check_field("evicted_layer", got_rsp.ev_layer, rsp_ch.evicted_layer);
          check_field("evicted_expert", got_rsp.ev_expert, rsp_ch.evicted_expert);
          check_field("slot", got_rsp.slot, rsp_ch.slot);
          check_field("used_bytes", got_rsp.used, rsp_ch.used_bytes);
        end
        case (rsp_ch.status)
          ST_HIT:    n_hit++;
          ST_INSERT: n_insert++;
          default:   n_reject++;
        endcase
        if (rsp_ch.evicted) n_evict++;
        if ($urandom_range(0, 49) == 0) mon_quiet = !mon_quiet;
        mon_gap = mon_quiet ? 0 : $urandom_range(0, 17);
      end
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the input side backs up
  initial begin
    wait (n_accepted >= 550);
    @(negedge clk);
    hold_rsp = 1'b1;
    repeat (300) @(negedge clk);
    hold_rsp = 1'b0;
  end

  initial begin : stim
    logic [63:0] r;
    logic [USED_W-1:0] budget;
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset budget of zero: eviction attempt on an empty table, then a real one
    queue_lookup(8'd0, 8'd0, 1'b1, 40'd1, 1'b0, 40'd0, 1'b0, 40'd0);
    queue_lookup(8'd3, 8'd3, 1'b0, 40'd0, 1'b1, 40'd9, 1'b0, 40'd0);
    drain_and_settle();

    set_budget(BUDGET_MAX);
    queue_lookup(8'd3, 8'd3, 1'b1, '1, 1'b1, '1, 1'b1, '1);
    queue_lookup(8'd255, 8'd255, 1'b1, '1, 1'b1, '1, 1'b1, '1);
    queue_lookup(8'd1, 8'd1, 1'b0, '1, 1'b0, '1, 1'b0, '1);
    queue_lookup(8'd1, 8'd1, 1'b1, '0, 1'b1, '0, 1'b1, '0);
    for (int i = 2; i < 16; i++)
      queue_lookup(KEY_W'(i), 8'hA5, 1'b1, PART_W'(i), 1'b0, '0, 1'b0, '0);
    queue_lookup(8'd200, 8'd100, 1'b0, '0, 1'b1, 40'd77, 1'b0, '0);
    queue_lookup(8'd201, 8'd101, 1'b0, '0, 1'b0, '0, 1'b0, '0);
    drain_and_settle();

    for (int p = 0; p < N_PHASES; p++) begin
      r = {$urandom, $urandom};
      case (p)
        0: begin budget = BUDGET_MAX; size_mode = SIZE_SMALL; n = 250; end
        1: begin budget = '0; size_mode = SIZE_SMALL; n = 150; end
        2: begin
          budget = USED_W'($urandom_range(2000, 40000)); size_mode = SIZE_SMALL; n = 300;
        end
        3: begin budget = r[USED_W-1:0]; size_mode = SIZE_WIDE; n = 250; end
        4: begin
          budget = (USED_W'(1) << 43) + r[40:0]; size_mode = SIZE_WIDE; n = 250;
        end
        5: begin budget = BUDGET_MAX; size_mode = SIZE_MIXED; n = 200; end
        6: begin
          budget = USED_W'($urandom_range(1, 8000)); size_mode = SIZE_MIXED; n = 200;
        end
        default: begin budget = USED_W'(1); size_mode = SIZE_SMALL; n = 180; end
      endcase
      for (int k = 0; k < POOL_N; k++) begin
        pool_layer[k]  = KEY_W'($urandom);
        pool_expert[k] = KEY_W'($urandom);
      end
      set_budget(budget);
      repeat (n) pending_req = {pending_req, rand_lookup()};
      drain_and_settle();
    end

    $display("covered %0d lookups over %0d budget settings:", n_accepted, n_settings);
    $display("  %0d hits, %0d inserts, %0d rejects, %0d evictions, %0d mismatches",
             n_hit, n_insert, n_reject, n_evict, n_fail);
    if (n_fail == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout waiting for the block to drain");
    $display("status: fail");
    $finish;
  end

endmodule
